[rtl/iptcs_pkg.sv]
// Shared types, constants and one's complement helpers for the IP/TCP/UDP
// checksum engine. No dependencies.
`timescale 1ns / 1ps

package iptcs_pkg;

    localparam logic [1:0] MODE_IPV4 = 2'd0;
    localparam logic [1:0] MODE_TCP  = 2'd1;
    localparam logic [1:0] MODE_UDP  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [15:0] PROTO_TCP = 16'd6;
    localparam logic [15:0] PROTO_UDP = 16'd17;

    localparam logic [3:0] POS_IPV4  = 4'd5;
    localparam logic [3:0] POS_TCP   = 4'd8;
    localparam logic [3:0] POS_UDP   = 4'd3;
    localparam logic [3:0] INDEX_MAX = 4'd15;

    localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
    localparam logic [15:0] ALL_ONES       = 16'hFFFF;
    localparam logic [15:0] ALL_ZEROS      = 16'h0000;

    // One captured input word, pseudo-header already folded.
    typedef struct packed {
        logic [1:0]  mode;
        logic        first;
        logic [15:0] data;
        logic        half;
        logic        last;
        logic [15:0] psum;
    } word_t;

    // End-around carry add; a single fold never overflows 16 bits.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        begin
            s = {1'b0, a} + {1'b0, b};
            f = {1'b0, s[15:0]} + {16'd0, s[16]};
            return f[15:0];
        end
    endfunction

    // Folded one's complement sum of the pseudo-header fields.
    function automatic logic [15:0] pseudo_sum(
        input logic [31:0] src,
        input logic [31:0] dst,
        input logic [15:0] proto,
        input logic [15:0] len
    );
        logic [18:0] s;
        logic [16:0] t;
        logic [16:0] u;
        begin
            s = {3'd0, src[31:16]} + {3'd0, src[15:0]} + {3'd0, dst[31:16]}
              + {3'd0, dst[15:0]} + {3'd0, proto} + {3'd0, len};
            t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
            u = {1'b0, t[15:0]} + {16'd0, t[16]};
            return u[15:0];
        end
    endfunction

    function automatic logic [3:0] check_pos(input logic [1:0] mode);
        logic [3:0] p;
        begin
            unique case (mode)
                MODE_TCP: p = POS_TCP;
                MODE_UDP: p = POS_UDP;
                default:  p = POS_IPV4;
            endcase
            return p;
        end
    endfunction

endpackage

[rtl/iptcs_core.sv]
// Running sum state and per-word checksum update for the checksum engine.
// Depends on iptcs_pkg.
`timescale 1ns / 1ps

module iptcs_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  iptcs_pkg::word_t     word,
    output logic [15:0]          checksum
);
    import iptcs_pkg::*;

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;

    logic [15:0] base;
    logic [3:0]  idx;
    logic [15:0] data;
    logic [15:0] inv;

    always_comb
    begin
        mode_next = word.first ? word.mode : mode_reg;
        idx       = word.first ? 4'd0 : idx_reg;
        if (word.first)
        begin
            base = (mode_next == MODE_IPV4) ? ALL_ZEROS : word.psum;
        end
        else
        begin
            base = sum_reg;
        end

        data = word.half ? (word.data & HIGH_BYTE_MASK) : word.data;
        // checksum field itself counts as zero
        if (idx == check_pos(mode_next))
        begin
            data = ALL_ZEROS;
        end

        sum_next = oc_add(base, data);
        idx_next = (idx == INDEX_MAX) ? INDEX_MAX : idx + 4'd1;

        inv = ~sum_next;
        if (mode_next == MODE_UDP && inv == ALL_ZEROS)
        begin
            checksum = ALL_ONES;
        end
        else
        begin
            checksum = inv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= ALL_ZEROS;
            idx_reg  <= 4'd0;
            mode_reg <= MODE_IPV4;
        end
        else if (go)
        begin
            sum_reg  <= sum_next;
            idx_reg  <= idx_next;
            mode_reg <= mode_next;
        end
    end

endmodule

[rtl/ip_tcp_udp_checksum_engine.sv]
// Top level of the IP/TCP/UDP checksum engine: input word register, output
// result register and handshakes. Depends on iptcs_pkg and iptcs_core.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one 16-bit packet word per
//   transfer with its framing bits (first, last, half_word), the mode in op
//   and, for the first word, the pseudo-header fields src_addr, dst_addr and
//   seg_len. Output channel (out_valid / out_stall) carries one checksum per
//   packet, produced by the word marked last.
//   A last word is held in the input register and, once the result slot is
//   free, is summed into the result register, which raises out_valid; the
//   checksum is then held there until it is taken.
//   Throughput: one word per cycle while no last word waits on a stalled
//   receiver; the running sum is a single end-around-carry add per word,
//   and the pseudo-header is folded while the first word is captured.
//   Reset clears the running sum, word index and mode, and empties both
//   registers. When the receiver stalls, the result register holds; words
//   without last keep flowing, and a last word waits in the input register,
//   with in_stall high, until the result slot frees.
module ip_tcp_udp_checksum_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic        first,
    input  logic [15:0] data_word,
    input  logic        half_word,
    input  logic        last,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] seg_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] checksum
);
    import iptcs_pkg::*;

    logic        s1_valid_reg;
    word_t       s1_word_reg;
    word_t       s1_word_next;
    logic        out_valid_reg;
    logic [15:0] checksum_reg;
    logic [15:0] core_checksum;
    logic        go;
    logic        accept;
    logic [1:0]  mode_in;

    assign go       = s1_valid_reg && (!s1_word_reg.last || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        mode_in = (op == MODE_RSVD) ? MODE_IPV4 : op;
        s1_word_next.mode  = mode_in;
        s1_word_next.first = first;
        s1_word_next.data  = data_word;
        s1_word_next.half  = half_word;
        s1_word_next.last  = last;
        s1_word_next.psum  = pseudo_sum(src_addr, dst_addr,
                                        (mode_in == MODE_TCP) ? PROTO_TCP : PROTO_UDP,
                                        seg_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= s1_word_next;
        end
    end

    iptcs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .word     (s1_word_reg),
        .checksum (core_checksum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && s1_word_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_word_reg.last)
        begin
            checksum_reg <= core_checksum;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

endmodule
